>>> sv/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared constants, codes and request types of the RPM crossfade unit.
// ----------------------------------------------------------------------------
package rcp_pkg;

	localparam int RPM_BITS    = 14;
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = 4;
	localparam int NUM_W       = 40;
	localparam int DEN_W       = 20;
	localparam int QUO_W       = 24;

	localparam logic [1:0] MODE_LIN = 2'd0;
	localparam logic [1:0] MODE_EQP = 2'd1;
	localparam logic [1:0] MODE_LOG = 2'd2;
	localparam logic [1:0] MODE_RSV = 2'd3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic CFG_FADE_MODE   = 1'b0;
	localparam logic CFG_ENTRY_COUNT = 1'b1;

	localparam logic [15:0] ONE_Q15       = 16'd32768;
	localparam logic [15:0] EDGE_EQ_POWER = 16'd23170;
	localparam logic [15:0] RATE_SAT      = 16'hFFFF;

	localparam logic signed [33:0] SIN_C1 = 34'sd1686629713;
	localparam logic signed [33:0] SIN_C3 = 34'sd693598668;
	localparam logic signed [33:0] SIN_C5 = 34'sd85569306;
	localparam logic signed [33:0] SIN_C7 = 34'sd5026995;
	localparam logic signed [33:0] SIN_C9 = 34'sd172272;

	localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
	localparam logic [27:0] LOG_K_Q32     = 28'd164062008;

	typedef logic [RPM_BITS-1:0] rpm_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             valid;
		logic             log_mode;
		logic [QUO_W-1:0] arg;
	} crv_req_t;

	// Horner coefficients after the u^9 term
	function automatic logic signed [33:0] sin_coef(input logic [1:0] step);
		logic signed [33:0] c;
		case (step)
			2'd0:    c = -SIN_C7;
			2'd1:    c = SIN_C5;
			2'd2:    c = -SIN_C3;
			default: c = SIN_C1;
		endcase
		return c;
	endfunction

endpackage

>>> sv/rpm_crossfade_param_unit.sv
// ----------------------------------------------------------------------------
// rpm_crossfade_param_unit
// Crossfade parameters for two engine samples around the current RPM.
// ----------------------------------------------------------------------------
// Use: registers are written through cfg_we/cfg_addr/cfg_wdata while the
// unit is idle (fade_mode at 1, entry_count at 1). An item is taken when
// start is high and busy low. A write item (req_type 0) stores entry_rpm in
// slot entry_index in that cycle and gives no result; busy stays low.
// A query item (req_type 1) raises busy until its result: done is high for
// exactly one cycle with the high and low sample fields, then busy drops.
// The receiver cannot stall; a result is gone after its done cycle.
// A query reads the table ends and, unless it lies at a table edge, searches
// slot by slot; then it runs up to four divides on the bit-serial divider
// (two rates, two volume arguments), and in equal-power or log mode the
// curve sequencer then shapes each volume.
// Reset clears registers and control; the table is not cleared and must be
// written before the slots a query reaches are read.
// ----------------------------------------------------------------------------
module rpm_crossfade_param_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_addr,
	input  logic [4:0]                cfg_wdata,
	input  logic                      start,
	output logic                      busy,
	input  logic                      req_type,
	input  logic [3:0]                entry_index,
	input  logic [13:0]               entry_rpm,
	input  logic [13:0]               query_rpm,
	output logic                      done,
	output logic                      high_present,
	output logic [3:0]                high_index,
	output logic [15:0]               high_rate,
	output logic [15:0]               high_volume,
	output logic                      low_present,
	output logic [3:0]                low_index,
	output logic [15:0]               low_rate,
	output logic [15:0]               low_volume
);
	import rcp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_SRD, S_SCHK, S_JOB, S_DWAIT, S_CWAIT, S_OUT
	} state_t;

	typedef enum logic [1:0] {J_HRATE, J_LRATE, J_HVOL, J_LVOL} job_t;

	state_t            state_q;
	job_t              job_q;
	logic [1:0]        fade_mode_q;
	logic [4:0]        entry_count_q;
	logic [1:0]        mode_q;
	rpm_t              q_q;
	rpm_t              hi_rpm_q;
	rpm_t              lo_rpm_q;
	logic [IDX_W-1:0]  nm1_q;
	logic [IDX_W-1:0]  i_q;
	logic              hp_q, lp_q;
	logic [3:0]        hidx_q, lidx_q;
	logic [15:0]       hrate_q, lrate_q, hvol_q, lvol_q;

	logic              accept;
	logic [IDX_W-1:0]  n_m1;
	logic [IDX_W-1:0]  raddr0, raddr1;
	rpm_t              rd0, rd1;
	rpm_t              d, a, na, rr;
	logic [1:0]        mode_eff;
	logic [15:0]       edge_vol;
	logic              job_rate, job_need, sat, last_job;
	div_req_t          div_req;
	crv_req_t          crv_req;
	logic [QUO_W-1:0]  div_quo;
	logic              div_done;
	logic [15:0]       crv_vol;
	logic              crv_done;

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign done   = state_q == S_OUT;

	always_comb begin
		if (entry_count_q == 5'd0) begin
			n_m1 = '0;
		end else if (entry_count_q > 5'(MAX_ENTRIES)) begin
			n_m1 = IDX_W'(MAX_ENTRIES - 1);
		end else begin
			n_m1 = IDX_W'(entry_count_q - 5'd1);
		end
	end

	assign raddr0 = (state_q == S_IDLE) ? '0 : i_q;
	assign raddr1 = (state_q == S_IDLE) ? n_m1 : i_q - 1'b1;

	rcp_mem u_mem (
		.clk    (clk),
		.we     (accept && req_type == REQ_WRITE),
		.waddr  (entry_index),
		.wdata  (entry_rpm),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	assign mode_eff = (fade_mode_q == MODE_RSV) ? MODE_LIN : fade_mode_q;
	assign edge_vol = (mode_eff == MODE_EQP) ? EDGE_EQ_POWER : ONE_Q15;

	assign d  = hi_rpm_q - lo_rpm_q;
	assign a  = q_q - lo_rpm_q;
	assign na = (job_q == J_HVOL) ? a : d - a;
	assign rr = (job_q == J_HRATE) ? hi_rpm_q : lo_rpm_q;

	assign job_rate = job_q == J_HRATE || job_q == J_LRATE;
	assign last_job = job_q == J_LVOL;
	assign sat      = {4'd0, q_q} >= {rr, 4'd0};

	always_comb begin
		case (job_q)
			J_HRATE: job_need = hp_q;
			J_LRATE: job_need = lp_q;
			default: job_need = hp_q && lp_q;
		endcase
	end

	always_comb begin
		div_req.valid = state_q == S_JOB && job_need && !(job_rate && sat);
		if (job_rate) begin
			div_req.num = NUM_W'(q_q) << 12;
			div_req.den = DEN_W'(rr);
		end else begin
			case (mode_q)
				MODE_EQP: begin
					div_req.num = (NUM_W'(na) << 17) + NUM_W'(d);
					div_req.den = DEN_W'(d) << 1;
				end
				MODE_LOG: begin
					div_req.num = NUM_W'(na) * NUM_W'(13107200) + NUM_W'(d);
					div_req.den = DEN_W'(d) << 1;
				end
				default: begin
					if (job_q == J_HVOL) begin
						div_req.num = (NUM_W'(a) << 16) + NUM_W'(d);
						div_req.den = DEN_W'(d) << 1;
					end else begin
						div_req.num = NUM_W'(na) * NUM_W'(589824) + NUM_W'(d) * NUM_W'(10);
						div_req.den = DEN_W'(d) * DEN_W'(20);
					end
				end
			endcase
		end
	end

	rcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign crv_req.valid    = state_q == S_DWAIT && div_done && !job_rate && mode_q != MODE_LIN;
	assign crv_req.log_mode = mode_q == MODE_LOG;
	assign crv_req.arg      = div_quo;

	rcp_crv u_crv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crv_req),
		.vol    (crv_vol),
		.done   (crv_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_mode_q   <= MODE_EQP;
			entry_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FADE_MODE:   fade_mode_q   <= cfg_wdata[1:0];
				CFG_ENTRY_COUNT: entry_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			job_q    <= J_HRATE;
			mode_q   <= MODE_LIN;
			q_q      <= '0;
			hi_rpm_q <= '0;
			lo_rpm_q <= '0;
			nm1_q    <= '0;
			i_q      <= '0;
			hp_q     <= 1'b0;
			lp_q     <= 1'b0;
			hidx_q   <= '0;
			lidx_q   <= '0;
			hrate_q  <= '0;
			lrate_q  <= '0;
			hvol_q   <= '0;
			lvol_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && req_type == REQ_QUERY) begin
						q_q     <= query_rpm;
						mode_q  <= mode_eff;
						nm1_q   <= n_m1;
						hp_q    <= 1'b0;
						lp_q    <= 1'b0;
						hidx_q  <= '0;
						lidx_q  <= '0;
						hrate_q <= '0;
						lrate_q <= '0;
						hvol_q  <= '0;
						lvol_q  <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					job_q <= J_HRATE;
					if (q_q >= rd1) begin
						lp_q     <= 1'b1;
						lidx_q   <= nm1_q;
						lo_rpm_q <= rd1;
						lvol_q   <= edge_vol;
						state_q  <= S_JOB;
					end else if (q_q <= rd0) begin
						hp_q     <= 1'b1;
						hidx_q   <= '0;
						hi_rpm_q <= rd0;
						hvol_q   <= edge_vol;
						state_q  <= S_JOB;
					end else begin
						i_q     <= IDX_W'(1);
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (rd0 >= q_q || i_q == nm1_q) begin
						hp_q     <= 1'b1;
						lp_q     <= 1'b1;
						hidx_q   <= i_q;
						lidx_q   <= i_q - 1'b1;
						hi_rpm_q <= rd0;
						lo_rpm_q <= rd1;
						state_q  <= S_JOB;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_JOB: begin
					if (!job_need || (job_rate && sat)) begin
						if (job_need) begin
							if (job_q == J_HRATE) hrate_q <= RATE_SAT;
							else lrate_q <= RATE_SAT;
						end
						if (last_job) state_q <= S_OUT;
						else job_q <= job_t'(job_q + 2'd1);
					end else begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (div_done) begin
						if (job_rate || mode_q == MODE_LIN) begin
							case (job_q)
								J_HRATE: hrate_q <= div_quo[15:0];
								J_LRATE: lrate_q <= div_quo[15:0];
								J_HVOL:  hvol_q  <= div_quo[15:0];
								default: lvol_q  <= div_quo[15:0];
							endcase
							if (last_job) begin
								state_q <= S_OUT;
							end else begin
								job_q   <= job_t'(job_q + 2'd1);
								state_q <= S_JOB;
							end
						end else begin
							state_q <= S_CWAIT;
						end
					end
				end
				S_CWAIT: begin
					if (crv_done) begin
						if (job_q == J_HVOL) hvol_q <= crv_vol;
						else lvol_q <= crv_vol;
						if (last_job) begin
							state_q <= S_OUT;
						end else begin
							job_q   <= job_t'(job_q + 2'd1);
							state_q <= S_JOB;
						end
					end
				end
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign high_present = hp_q;
	assign high_index   = hidx_q;
	assign high_rate    = hrate_q;
	assign high_volume  = hvol_q;
	assign low_present  = lp_q;
	assign low_index    = lidx_q;
	assign low_rate     = lrate_q;
	assign low_volume   = lvol_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_side_present: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (high_present || low_present)) else $error("result with no sample");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !high_present) |-> (high_rate == 16'd0 && high_volume == 16'd0))
		else $error("absent high side not zero");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_QUERY) |=> busy) else $error("query not taken");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_WRITE) |=> !busy) else $error("write left unit busy");

endmodule

>>> sv/rcp_mem.sv
// ----------------------------------------------------------------------------
// rcp_mem
// RPM table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rcp_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [rcp_pkg::IDX_W-1:0] waddr,
	input  rcp_pkg::rpm_t             wdata,
	input  logic [rcp_pkg::IDX_W-1:0] raddr0,
	input  logic [rcp_pkg::IDX_W-1:0] raddr1,
	output rcp_pkg::rpm_t             rdata0,
	output rcp_pkg::rpm_t             rdata1
);
	import rcp_pkg::*;

	rpm_t mem_q [MAX_ENTRIES];
	rpm_t rd0_q;
	rpm_t rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd0_q <= mem_q[raddr0];
		rd1_q <= mem_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

>>> sv/rcp_div.sv
// ----------------------------------------------------------------------------
// rcp_div
// Restoring divider, one quotient bit per cycle. The upper dividend part
// must be below the divisor.
// ----------------------------------------------------------------------------
module rcp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rcp_pkg::div_req_t         req,
	output logic [rcp_pkg::QUO_W-1:0] quo,
	output logic                      done
);
	import rcp_pkg::*;

	localparam int CW = $clog2(QUO_W);
	localparam logic [CW-1:0] CNT_LAST = CW'(QUO_W - 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] sh_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fit;

	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.valid) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			rem_q <= DEN_W'(req.num[NUM_W-1:QUO_W]);
			den_q <= req.den;
			sh_q  <= req.num[QUO_W-1:0];
		end else if (run_q) begin
			rem_q <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], fit};
		end
	end

	assign quo  = sh_q;
	assign done = done_q;

endmodule

>>> sv/rcp_crv.sv
// ----------------------------------------------------------------------------
// rcp_crv
// Volume curves: Q30 sine polynomial by Horner, or log2 by repeated
// squaring, then scaling and rounding to Q1.15.
// ----------------------------------------------------------------------------
module rcp_crv (
	input  logic              clk,
	input  logic              arst_n,
	input  rcp_pkg::crv_req_t req,
	output logic [15:0]       vol,
	output logic              done
);
	import rcp_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE, C_SQ, C_HM, C_HA, C_TM, C_TA, C_CL, C_LM, C_LA, C_LK, C_RN
	} crv_state_t;

	crv_state_t         state_q;
	logic [16:0]        t_q;
	logic [16:0]        x2_q;
	logic signed [33:0] acc_q;
	logic signed [51:0] prod_q;
	logic [1:0]         step_q;
	logic [30:0]        m_q;
	logic [61:0]        sq_q;
	logic [2:0]         p_q;
	logic [15:0]        frac_q;
	logic [3:0]         k_q;
	logic [60:0]        fin_q;
	logic               log_q;
	logic [15:0]        vol_q;
	logic               done_q;

	logic [23:0]        y;
	logic [2:0]         pe;
	logic [37:0]        ysh;
	logic signed [51:0] adj;
	logic signed [33:0] trq;
	logic [30:0]        clamped;
	logic [31:0]        m2;
	logic [33:0]        t2;
	logic [61:0]        rnd;

	always_comb begin
		y  = req.arg + 24'h010000;
		pe = 3'd0;
		for (int j = 17; j < 24; j++) begin
			if (y[j]) begin
				pe = 3'(j - 16);
			end
		end
		ysh = {14'd0, y} << (4'd14 - {1'b0, pe});
	end

	assign adj = prod_q + (prod_q[51] ? 52'sd65535 : 52'sd0);
	assign trq = 34'(adj >>> 16);
	assign clamped = acc_q[33] ? 31'd0 :
		(acc_q > 34'sd1073741824) ? 31'd1073741824 : acc_q[30:0];
	assign m2  = sq_q[61:30];
	assign t2  = 34'(t_q) * 34'(t_q);
	assign rnd = log_q ? ({1'b0, fin_q} + (62'd1 << 47)) >> 48
		: ({1'b0, fin_q} + (62'd1 << 44)) >> 45;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			t_q     <= '0;
			x2_q    <= '0;
			acc_q   <= '0;
			prod_q  <= '0;
			step_q  <= '0;
			m_q     <= '0;
			sq_q    <= '0;
			p_q     <= '0;
			frac_q  <= '0;
			k_q     <= '0;
			fin_q   <= '0;
			log_q   <= 1'b0;
			vol_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.valid) begin
						log_q  <= req.log_mode;
						t_q    <= req.arg[16:0];
						acc_q  <= SIN_C9;
						step_q <= '0;
						m_q    <= ysh[30:0];
						p_q    <= pe;
						frac_q <= '0;
						k_q    <= '0;
						state_q <= req.log_mode ? C_LM : C_SQ;
					end
				end
				C_SQ: begin
					x2_q    <= t2[32:16];
					state_q <= C_HM;
				end
				C_HM: begin
					prod_q  <= 52'(acc_q) * 52'($signed({1'b0, x2_q}));
					state_q <= C_HA;
				end
				C_HA: begin
					acc_q  <= sin_coef(step_q) + trq;
					step_q <= step_q + 1'b1;
					state_q <= (step_q == 2'd3) ? C_TM : C_HM;
				end
				C_TM: begin
					prod_q  <= 52'(acc_q) * 52'($signed({1'b0, t_q}));
					state_q <= C_TA;
				end
				C_TA: begin
					acc_q   <= trq;
					state_q <= C_CL;
				end
				C_CL: begin
					fin_q   <= 61'(clamped) * 61'(INV_SQRT2_Q30);
					state_q <= C_RN;
				end
				C_LM: begin
					sq_q    <= 62'(m_q) * 62'(m_q);
					state_q <= C_LA;
				end
				C_LA: begin
					if (m2[31]) begin
						m_q         <= m2[31:1];
						frac_q[~k_q] <= 1'b1;
					end else begin
						m_q <= m2[30:0];
					end
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == 4'd15) ? C_LK : C_LM;
				end
				C_LK: begin
					fin_q   <= 61'({p_q, frac_q}) * 61'(LOG_K_Q32);
					state_q <= C_RN;
				end
				C_RN: begin
					vol_q   <= rnd[15:0];
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign vol  = vol_q;
	assign done = done_q;

endmodule
